// File: rtl/acr_pkg.sv
package acr_pkg;

    localparam int          RATE_W      = 20;
    localparam int          CNT_W       = 3;
    localparam int          MAX_RATES_D = 4;
    localparam logic [2:0]  OP_GET      = 3'd0;
    localparam logic [2:0]  OP_SET      = 3'd1;
    localparam logic [2:0]  OP_ALT      = 3'd2;
    localparam logic [2:0]  OP_CLOSE    = 3'd3;
    localparam logic [2:0]  OP_REENUM   = 3'd4;
    localparam logic [7:0]  ENT_CLOCK   = 8'h04;
    localparam logic [7:0]  ENT_FEATURE = 8'h02;
    localparam logic [7:0]  SEL_FREQ    = 8'd1;
    localparam logic [7:0]  SEL_VALID   = 8'd2;
    localparam logic [7:0]  SEL_MUTE    = 8'd1;
    localparam logic [7:0]  SEL_VOLUME  = 8'd2;
    localparam logic [7:0]  REQ_CUR     = 8'd1;
    localparam logic [7:0]  REQ_RANGE   = 8'd2;
    localparam logic [2:0]  CFG_RATE_A  = 3'd0;
    localparam logic [2:0]  CFG_RATE_B  = 3'd1;
    localparam logic [2:0]  CFG_RATE_C  = 3'd2;
    localparam logic [2:0]  CFG_RATE_D  = 3'd3;
    localparam logic [2:0]  CFG_COUNT   = 3'd4;
    localparam logic [2:0]  CFG_DEFSLOT = 3'd5;
    localparam logic [16:0] UNITY       = 17'd65536;
    localparam logic [31:0] COARSE_STEP = 32'd3827893632;
    localparam logic [31:0] FINE_STEP   = 32'd4293036182;
    localparam logic [31:0] VOL_MIN     = 32'h0000_9C00;
    localparam logic [31:0] VOL_RES     = 32'h0000_0100;
    localparam logic [RATE_W-1:0] RATE_A_RST = 20'd44100;
    localparam logic [RATE_W-1:0] RATE_B_RST = 20'd48000;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  entity_id;
        logic [7:0]  control_selector;
        logic [7:0]  request_code;
        logic [31:0] set_value;
        logic [7:0]  alt_setting;
    } t_req;

    typedef struct packed {
        logic        accepted;
        logic [31:0] data_word;
        logic [2:0]  data_bytes;
        logic        last;
        logic [16:0] gain_q16;
        logic        streaming;
        logic [19:0] current_rate;
    } t_rsp;

    typedef enum logic [2:0] {
        K_STALL, K_ACK, K_RATE_CUR, K_RATE_RANGE, K_VALID, K_MUTE, K_VOL_CUR, K_VOL_RANGE
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_GSET, S_GC, S_GF, S_GP, S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic gset;
        logic gc;
        logic gf;
        logic gp;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic gain_req;
        logic ca_zero;
        logic cb_zero;
        logic last_word;
    } t_sts;

endpackage

// File: rtl/acr_ctrl.sv
module acr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  acr_pkg::t_sts  i_sts,
    output acr_pkg::t_cmd  o_cmd,
    output logic           o_busy
);

    acr_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= acr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            acr_pkg::S_IDLE: begin
                if (i_start) n_state = acr_pkg::S_EXEC;
            end
            acr_pkg::S_EXEC: begin
                n_state = i_sts.gain_req ? acr_pkg::S_GSET : acr_pkg::S_EMIT;
            end
            acr_pkg::S_GSET: n_state = acr_pkg::S_GC;
            acr_pkg::S_GC: begin
                if (i_sts.ca_zero) n_state = acr_pkg::S_GF;
            end
            acr_pkg::S_GF: begin
                if (i_sts.cb_zero) n_state = acr_pkg::S_GP;
            end
            acr_pkg::S_GP: n_state = acr_pkg::S_EMIT;
            acr_pkg::S_EMIT: begin
                if (i_sts.last_word) n_state = acr_pkg::S_IDLE;
            end
            default: n_state = acr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_busy     = (r_state != acr_pkg::S_IDLE);
        o_cmd.load = (r_state == acr_pkg::S_IDLE) && i_start;
        o_cmd.exec = (r_state == acr_pkg::S_EXEC);
        o_cmd.gset = (r_state == acr_pkg::S_GSET);
        o_cmd.gc   = (r_state == acr_pkg::S_GC) && !i_sts.ca_zero;
        o_cmd.gf   = (r_state == acr_pkg::S_GF) && !i_sts.cb_zero;
        o_cmd.gp   = (r_state == acr_pkg::S_GP);
        o_cmd.emit = (r_state == acr_pkg::S_EMIT);
    end

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == acr_pkg::S_EXEC))
        else $error("load did not enter exec");
    a_gp_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.gp |=> o_cmd.emit)
        else $error("gain result not followed by emit");
    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_cmd.emit) |-> ($past(o_cmd.exec) || $past(o_cmd.gp)))
        else $error("emit entered from wrong state");

endmodule

// File: rtl/acr_dp.sv
module acr_dp #(
    parameter int MAX_RATES = acr_pkg::MAX_RATES_D
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  acr_pkg::t_req              i_req,
    input  acr_pkg::t_cmd              i_cmd,
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_index,
    input  logic [acr_pkg::RATE_W-1:0] i_cfg_data,
    output acr_pkg::t_sts              o_sts,
    output logic                       o_rsp_valid,
    output acr_pkg::t_rsp              o_rsp
);

    logic [acr_pkg::RATE_W-1:0] r_rate [MAX_RATES];
    logic [2:0]                 r_count_cfg;
    logic [1:0]                 r_defslot;
    logic [acr_pkg::RATE_W-1:0] r_chosen;
    logic                       r_muted;
    logic [15:0]                r_vol;
    logic [16:0]                r_gain;
    logic                       r_stream;
    acr_pkg::t_req              r_req;
    acr_pkg::t_kind             r_kind, n_kind;
    logic [3:0]                 r_k;
    logic [7:0]                 r_ca;
    logic [7:0]                 r_cb;
    logic [32:0]                r_coarse;
    logic [32:0]                r_fine;
    logic                       r_strobe;
    acr_pkg::t_rsp              r_rsp;

    logic [acr_pkg::CNT_W-1:0]  w_n;
    logic [acr_pkg::RATE_W-1:0] w_def_rate;
    logic                       w_match;
    logic                       w_gain_req;
    logic [16:0]                w_m;
    logic [31:0]                w_ma, w_mb;
    logic [63:0]                w_rnd;
    logic [32:0]                w_p;
    logic [16:0]                w_gcalc;
    logic [1:0]                 w_slot;
    logic [1:0]                 w_pos;
    logic [acr_pkg::RATE_W-1:0] w_slot_rate;
    logic [3:0]                 w_klast;
    logic                       w_last;
    acr_pkg::t_rsp              w_word;

    always_comb begin
        int s;
        w_n = (r_count_cfg == 3'd0) ? 3'd1 :
              (r_count_cfg > 3'(MAX_RATES)) ? 3'(MAX_RATES) : r_count_cfg;
        s = (int'(r_defslot) >= MAX_RATES) ? MAX_RATES - 1 : int'(r_defslot);
        w_def_rate = '0;
        w_match    = 1'b0;
        w_slot_rate = '0;
        for (int i = 0; i < MAX_RATES; i++) begin
            if (i == s) w_def_rate = r_rate[i];
            if (i == int'(w_slot)) w_slot_rate = r_rate[i];
            if ((3'(i) < w_n) && ({12'd0, r_rate[i]} == r_req.set_value)) w_match = 1'b1;
        end
    end

    always_comb begin
        n_kind     = acr_pkg::K_STALL;
        w_gain_req = 1'b0;
        priority case (r_req.opcode)
            acr_pkg::OP_GET: begin
                if (r_req.entity_id == acr_pkg::ENT_CLOCK) begin
                    if (r_req.control_selector == acr_pkg::SEL_FREQ &&
                        r_req.request_code == acr_pkg::REQ_CUR)
                        n_kind = acr_pkg::K_RATE_CUR;
                    else if (r_req.control_selector == acr_pkg::SEL_FREQ &&
                             r_req.request_code == acr_pkg::REQ_RANGE)
                        n_kind = acr_pkg::K_RATE_RANGE;
                    else if (r_req.control_selector == acr_pkg::SEL_VALID &&
                             r_req.request_code == acr_pkg::REQ_CUR)
                        n_kind = acr_pkg::K_VALID;
                end else if (r_req.entity_id == acr_pkg::ENT_FEATURE &&
                             (r_req.request_code == acr_pkg::REQ_CUR ||
                              r_req.request_code == acr_pkg::REQ_RANGE)) begin
                    if (r_req.control_selector == acr_pkg::SEL_MUTE &&
                        r_req.request_code == acr_pkg::REQ_CUR)
                        n_kind = acr_pkg::K_MUTE;
                    else if (r_req.control_selector == acr_pkg::SEL_VOLUME)
                        n_kind = (r_req.request_code == acr_pkg::REQ_RANGE) ?
                                 acr_pkg::K_VOL_RANGE : acr_pkg::K_VOL_CUR;
                end
            end
            acr_pkg::OP_SET: begin
                if (r_req.entity_id == acr_pkg::ENT_CLOCK &&
                    r_req.control_selector == acr_pkg::SEL_FREQ) begin
                    if (w_match) n_kind = acr_pkg::K_ACK;
                end else if (r_req.entity_id == acr_pkg::ENT_FEATURE &&
                             (r_req.control_selector == acr_pkg::SEL_MUTE ||
                              r_req.control_selector == acr_pkg::SEL_VOLUME)) begin
                    n_kind     = acr_pkg::K_ACK;
                    w_gain_req = 1'b1;
                end
            end
            acr_pkg::OP_ALT, acr_pkg::OP_CLOSE, acr_pkg::OP_REENUM: n_kind = acr_pkg::K_ACK;
            default: n_kind = acr_pkg::K_STALL;
        endcase
    end

    assign w_m  = 17'h10000 - {1'b0, r_vol};
    assign w_ma = i_cmd.gc ? r_coarse[31:0] : r_fine[31:0];
    assign w_mb = i_cmd.gc ? acr_pkg::COARSE_STEP :
                  i_cmd.gf ? acr_pkg::FINE_STEP : r_coarse[31:0];
    assign w_rnd = 64'(w_ma) * 64'(w_mb) + 64'h0000_0000_8000_0000;
    assign w_p = r_coarse[32] ? r_fine : r_fine[32] ? r_coarse : {1'b0, w_rnd[63:32]};
    assign w_gcalc = 17'((34'(w_p) + 34'd32768) >> 16);

    always_comb begin
        w_slot = 2'd0;
        w_pos  = 2'd0;
        unique case (r_k)
            4'd1:  begin w_slot = 2'd0; w_pos = 2'd0; end
            4'd2:  begin w_slot = 2'd0; w_pos = 2'd1; end
            4'd3:  begin w_slot = 2'd0; w_pos = 2'd2; end
            4'd4:  begin w_slot = 2'd1; w_pos = 2'd0; end
            4'd5:  begin w_slot = 2'd1; w_pos = 2'd1; end
            4'd6:  begin w_slot = 2'd1; w_pos = 2'd2; end
            4'd7:  begin w_slot = 2'd2; w_pos = 2'd0; end
            4'd8:  begin w_slot = 2'd2; w_pos = 2'd1; end
            4'd9:  begin w_slot = 2'd2; w_pos = 2'd2; end
            4'd10: begin w_slot = 2'd3; w_pos = 2'd0; end
            4'd11: begin w_slot = 2'd3; w_pos = 2'd1; end
            4'd12: begin w_slot = 2'd3; w_pos = 2'd2; end
            default: begin w_slot = 2'd0; w_pos = 2'd0; end
        endcase
    end

    assign w_klast = {w_n, 1'b0} + {1'b0, w_n};

    always_comb begin
        unique case (r_kind)
            acr_pkg::K_RATE_RANGE: w_last = (r_k == w_klast);
            acr_pkg::K_VOL_RANGE:  w_last = (r_k == 4'd3);
            default:               w_last = 1'b1;
        endcase
    end

    always_comb begin
        w_word              = '0;
        w_word.accepted     = 1'b1;
        w_word.last         = w_last;
        w_word.gain_q16     = r_gain;
        w_word.streaming    = r_stream;
        w_word.current_rate = r_chosen;
        unique case (r_kind)
            acr_pkg::K_STALL: w_word.accepted = 1'b0;
            acr_pkg::K_ACK: ;
            acr_pkg::K_RATE_CUR: begin
                w_word.data_word  = {12'd0, r_chosen};
                w_word.data_bytes = 3'd4;
            end
            acr_pkg::K_RATE_RANGE: begin
                if (r_k == 4'd0) begin
                    w_word.data_word  = {29'd0, w_n};
                    w_word.data_bytes = 3'd2;
                end else begin
                    w_word.data_word  = (w_pos == 2'd2) ? 32'd0 : {12'd0, w_slot_rate};
                    w_word.data_bytes = 3'd4;
                end
            end
            acr_pkg::K_VALID: begin
                w_word.data_word  = 32'd1;
                w_word.data_bytes = 3'd1;
            end
            acr_pkg::K_MUTE: begin
                w_word.data_word  = {31'd0, r_muted};
                w_word.data_bytes = 3'd1;
            end
            acr_pkg::K_VOL_CUR: begin
                w_word.data_word  = {16'd0, r_vol};
                w_word.data_bytes = 3'd2;
            end
            acr_pkg::K_VOL_RANGE: begin
                w_word.data_bytes = 3'd2;
                unique case (r_k[1:0])
                    2'd0: w_word.data_word = 32'd1;
                    2'd1: w_word.data_word = acr_pkg::VOL_MIN;
                    2'd2: w_word.data_word = 32'd0;
                    2'd3: w_word.data_word = acr_pkg::VOL_RES;
                    default: w_word.data_word = 32'd0;
                endcase
            end
            default: w_word.accepted = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_RATES; i++) begin
                r_rate[i] <= (i == 0) ? acr_pkg::RATE_A_RST :
                             (i == 1) ? acr_pkg::RATE_B_RST : '0;
            end
            r_count_cfg <= 3'd2;
            r_defslot   <= 2'd0;
            r_chosen    <= acr_pkg::RATE_A_RST;
            r_muted     <= 1'b0;
            r_vol       <= '0;
            r_gain      <= acr_pkg::UNITY;
            r_stream    <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index <= acr_pkg::CFG_RATE_D) begin
                    for (int i = 0; i < MAX_RATES; i++) begin
                        if (i_cfg_index == 3'(i)) r_rate[i] <= i_cfg_data;
                    end
                end else if (i_cfg_index == acr_pkg::CFG_COUNT) begin
                    r_count_cfg <= i_cfg_data[2:0];
                end else if (i_cfg_index == acr_pkg::CFG_DEFSLOT) begin
                    r_defslot <= i_cfg_data[1:0];
                end
            end
            if (i_cmd.exec) begin
                priority case (r_req.opcode)
                    acr_pkg::OP_SET: begin
                        if (n_kind == acr_pkg::K_ACK) begin
                            if (r_req.entity_id == acr_pkg::ENT_CLOCK)
                                r_chosen <= r_req.set_value[acr_pkg::RATE_W-1:0];
                            else if (r_req.control_selector == acr_pkg::SEL_MUTE)
                                r_muted <= (r_req.set_value[7:0] != 8'd0);
                            else
                                r_vol <= r_req.set_value[15:0];
                        end
                    end
                    acr_pkg::OP_ALT:   r_stream <= (r_req.alt_setting != 8'd0);
                    acr_pkg::OP_CLOSE: r_stream <= 1'b0;
                    acr_pkg::OP_REENUM: begin
                        r_stream <= 1'b0;
                        r_chosen <= w_def_rate;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.gp) begin
                r_gain <= r_muted ? 17'd0 : !r_vol[15] ? acr_pkg::UNITY : w_gcalc;
            end
            r_strobe <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_req <= i_req;
        if (i_cmd.exec) begin
            r_kind <= n_kind;
            r_k    <= '0;
        end
        if (i_cmd.gset) begin
            r_coarse <= 33'h1_0000_0000;
            r_fine   <= 33'h1_0000_0000;
            if (r_muted || !r_vol[15]) begin
                r_ca <= '0;
                r_cb <= '0;
            end else begin
                r_ca <= w_m[15:8] | {w_m[16], 7'd0};
                r_cb <= w_m[7:0];
            end
        end
        if (i_cmd.gc) begin
            r_coarse <= r_coarse[32] ? {1'b0, acr_pkg::COARSE_STEP} : {1'b0, w_rnd[63:32]};
            r_ca     <= r_ca - 8'd1;
        end
        if (i_cmd.gf) begin
            r_fine <= r_fine[32] ? {1'b0, acr_pkg::FINE_STEP} : {1'b0, w_rnd[63:32]};
            r_cb   <= r_cb - 8'd1;
        end
        if (i_cmd.emit) begin
            r_rsp <= w_word;
            r_k   <= r_k + 4'd1;
        end
    end

    assign o_sts.gain_req  = w_gain_req;
    assign o_sts.ca_zero   = (r_ca == 8'd0);
    assign o_sts.cb_zero   = (r_cb == 8'd0);
    assign o_sts.last_word = w_last;
    assign o_rsp_valid     = r_strobe;
    assign o_rsp           = r_rsp;

    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(i_cmd.emit))
        else $error("result word without emit");
    a_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && !r_rsp.accepted) |-> (r_rsp.data_bytes == 3'd0 && r_rsp.last))
        else $error("stall word carries data");
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gain <= acr_pkg::UNITY)
        else $error("gain above unity");

endmodule

// File: rtl/audio_class_control_responder.sv
// Control responder for one clock source and one feature unit.
// Request channel: drive i_req and raise start; the word is taken on a
// rising edge where start is high and busy is low.
// Result channel: each result word is on o_rsp for one cycle with
// o_rsp_valid high; there is no back-pressure, the receiver cannot stall.
// Configuration: i_cfg_valid/o_cfg_ready with register index and data;
// o_cfg_ready is always high, write only while the block is idle.
// Flow: an accepted request goes to EXEC, then EMIT gives one word per
// cycle (range of sample rates: up to 13 words). A volume or mute set runs
// the gain unit first: one shared 32x32 multiplier iterated once per coarse
// dB step and once per fine step, plus a final product step; the next item
// is accepted in the cycle the last word is shown.
// Reset: rates 44100 and 48000 offered, rate 44100, unmuted, volume 0,
// gain unity, streaming off.
module audio_class_control_responder #(
    parameter int MAX_RATES = acr_pkg::MAX_RATES_D
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  acr_pkg::t_req              i_req,
    output logic                       o_rsp_valid,
    output acr_pkg::t_rsp              o_rsp,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [2:0]                 i_cfg_index,
    input  logic [acr_pkg::RATE_W-1:0] i_cfg_data
);

    acr_pkg::t_cmd w_cmd;
    acr_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    acr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    acr_dp #(.MAX_RATES(MAX_RATES)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (w_cmd),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_sts       (w_sts),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp)
    );

endmodule
